FILE: sv/base64_stream_encoder_macros.svh
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Concurrent assertion helpers shared by the encoder RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define B64_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define B64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define B64_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define B64_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/b64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder package
// Payload types, group queue sizing and the standard alphabet lookup.
// ----------------------------------------------------------------------------
package b64enc_pkg;

	// ASCII anchors of the standard alphabet
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	// Group queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	// Result item
	typedef struct packed {
		logic [7:0] code_char;
		logic       final_char;
	} char_item_t;

	// One completed group: left aligned bits, byte count 1..3, final flag
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  cnt;
		logic        last;
	} group_t;

	// Sextet to ASCII in the standard alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return 8'(CH_UPPER_A + w);
		else if (v < 6'd52)
			return 8'(CH_LOWER_A + w - 8'd26);
		else if (v < 6'd62)
			return 8'(CH_DIGIT_0 + w - 8'd52);
		else if (v == 6'd62)
			return CH_PLUS;
		else
			return CH_SLASH;
	endfunction

endpackage

FILE: sv/b64enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder front
// Accepts bytes, holds up to two, and pushes each completed group.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64enc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  b64enc_pkg::byte_item_t byte_data,
	output logic                   push,
	output b64enc_pkg::group_t     push_item,
	input  logic                   q_full
);
	import b64enc_pkg::*;

	logic [15:0] held_bytes_q;
	logic [1:0]  held_count_q;
	logic [1:0]  cnt_next;
	logic        accept;
	logic        complete;

	// Stall only on a full queue; holding steps could pass but keep it simple
	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;
	assign cnt_next   = held_count_q + 2'd1;
	assign complete   = (cnt_next == 2'd3) || byte_data.final_byte;
	assign push       = accept && complete;

	// Left-align the group; missing low bytes are zero
	always_comb begin
		push_item.cnt  = cnt_next;
		push_item.last = byte_data.final_byte;
		case (held_count_q)
			2'd0:    push_item.bits = {byte_data.data_byte, 16'h0000};
			2'd1:    push_item.bits = {held_bytes_q[7:0], byte_data.data_byte, 8'h00};
			default: push_item.bits = {held_bytes_q, byte_data.data_byte};
		endcase
	end

	// Held bytes and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q <= '0;
			held_count_q <= '0;
		end else if (accept) begin
			if (complete) begin
				held_bytes_q <= '0;
				held_count_q <= '0;
			end else begin
				held_bytes_q <= {held_bytes_q[7:0], byte_data.data_byte};
				held_count_q <= cnt_next;
			end
		end
	end

	`B64_ASSERT_IMPLIES(a_count_range, clk, arst_n, 1'b1, held_count_q != 2'd3)

endmodule

FILE: sv/b64enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short FIFO of completed groups between front and back.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64enc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64enc_pkg::group_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output b64enc_pkg::group_t head
);
	import b64enc_pkg::*;

	group_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`B64_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, full, !push)
	`B64_ASSERT_IMPLIES(a_no_underflow, clk, arst_n, !not_empty, !pop)

endmodule

FILE: sv/b64enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder back
// Expands one group into four characters, one per cycle while the receiver does not stall, into the output register.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64enc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  b64enc_pkg::group_t     q_item,
	output logic                   q_pop,
	output logic                   char_valid,
	input  logic                   char_stall,
	output b64enc_pkg::char_item_t char_data
);
	import b64enc_pkg::*;

	group_t     grp_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       char_valid_q;
	char_item_t char_q;
	logic       emit;
	logic       done;
	logic       load;
	logic [5:0] sextet;
	char_item_t next_char;

	// Output register is free or being drained this cycle
	assign emit  = busy_q && (!char_valid_q || !char_stall);
	assign done  = emit && (idx_q == 2'd3);
	assign load  = (!busy_q || done) && q_valid;
	assign q_pop = load;

	// Pick the sextet for the current character
	always_comb begin
		case (idx_q)
			2'd0:    sextet = grp_q.bits[23:18];
			2'd1:    sextet = grp_q.bits[17:12];
			2'd2:    sextet = grp_q.bits[11:6];
			default: sextet = grp_q.bits[5:0];
		endcase
		next_char.code_char  = (idx_q > grp_q.cnt) ? CH_PAD : b64_char(sextet);
		next_char.final_char = grp_q.last && (idx_q == 2'd3);
	end

	// Group payload
	always_ff @(posedge clk) begin
		if (load)
			grp_q <= q_item;
		if (emit)
			char_q <= next_char;
	end

	// Character sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			idx_q        <= '0;
			char_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit)
				char_valid_q <= 1'b1;
			else if (!char_stall)
				char_valid_q <= 1'b0;
		end
	end

	assign char_valid = char_valid_q;
	assign char_data  = char_q;

	`B64_ASSERT_IMPLIES(a_busy_count, clk, arst_n, busy_q, grp_q.cnt != 2'd0)
	`B64_ASSERT_NEXT(a_done_idle, clk, arst_n, done && !q_valid, !busy_q)

endmodule

FILE: sv/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Streaming base64 encoder with the standard alphabet and '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_data) takes one raw byte per
//   transfer; final_byte marks the last byte of a message.
//   Char channel (char_valid / char_stall / char_data) gives one ASCII
//   character per transfer; final_char marks the last character of a message.
//   Every third byte, or a byte flagged final, closes a group of four
//   characters. Short final groups are padded with '='.
//   The byte that closes a group is written to the group queue; the back
//   expander then loads the group and registers its first character.
//   Throughput: one character per cycle from the back expander while the
//   receiver does not stall; bytes are taken at up to one per cycle while
//   the two-entry group queue has room.
//   Reset clears held bytes, the group queue pointers and the output valid.
//   When the receiver stalls, the output holds its character, the expander
//   waits, the queue fills and byte_stall then rises.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  b64enc_pkg::byte_item_t byte_data,
	output logic                   char_valid,
	input  logic                   char_stall,
	output b64enc_pkg::char_item_t char_data
);
	import b64enc_pkg::*;

	logic   push;
	group_t push_item;
	logic   q_full;
	logic   q_pop;
	logic   q_valid;
	group_t q_head;

	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	b64enc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	b64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule

FILE: verif/base64_stream_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Sends raw bytes grouped into messages over the byte channel and checks each
// character against a local model of the encoder. The directed rows cover the
// all-zero and all-one groups, short final groups and the '+' and '/' codes.
// The random part sends messages of random length and content. Both sides
// insert random idle cycles.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;
	import b64enc_pkg::*;

	// Standard alphabet with the pad character at index 64
	localparam logic [8*65-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
	localparam int PAD_SEXTET   = 64;
	localparam int RANDOM_BYTES = 300;
	localparam int DRAIN_CYCLES = 8;

	// One directed row: byte, final flag, and typed characters where known
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [31:0] chars;
	} stim_row_t;

	localparam int ROWS = 22;
	localparam stim_row_t DIRECTED_ROWS [ROWS] = '{
		{8'h00, 1'b1, 1'b1, "AA=="},
		{8'hFF, 1'b1, 1'b1, "/w=="},
		{8'hFF, 1'b0, 1'b0, 32'h0},
		{8'hFF, 1'b1, 1'b1, "//8="},
		{8'h00, 1'b0, 1'b0, 32'h0},
		{8'h00, 1'b0, 1'b0, 32'h0},
		{8'h00, 1'b0, 1'b1, "AAAA"},
		{8'hFF, 1'b0, 1'b0, 32'h0},
		{8'hFF, 1'b0, 1'b0, 32'h0},
		{8'hFF, 1'b0, 1'b1, "////"},
		{8'h00, 1'b0, 1'b0, 32'h0},
		{8'h00, 1'b0, 1'b0, 32'h0},
		{8'hFF, 1'b1, 1'b0, 32'h0},
		{8'h4D, 1'b0, 1'b0, 32'h0},
		{8'h61, 1'b0, 1'b0, 32'h0},
		{8'h6E, 1'b0, 1'b0, 32'h0},
		{8'hFB, 1'b0, 1'b0, 32'h0},
		{8'hEF, 1'b0, 1'b0, 32'h0},
		{8'hBE, 1'b1, 1'b0, 32'h0},
		{8'h80, 1'b1, 1'b0, 32'h0},
		{8'h01, 1'b0, 1'b0, 32'h0},
		{8'h7F, 1'b1, 1'b0, 32'h0}
	};

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_data  = '0;
	logic       char_valid;
	logic       char_stall = 1'b0;
	char_item_t char_data;

	// Expected characters, oldest first
	char_item_t expected_chars [$];

	// Model state: bytes of the open group and their number
	logic [15:0] pending_bytes = '0;
	logic [1:0]  pending_count = '0;

	int errors    = 0;
	bit byte_idle = 1'b1;
	bit char_idle = 1'b1;
	int char_wait = 0;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

	always #1 clk = ~clk;

	// Sextet index (or pad) to ASCII
	function automatic logic [7:0] sextet_char(input int idx);
		return ALPHABET[8*(64-idx) +: 8];
	endfunction

	// Advance the model by one byte; a closed group yields four characters
	task automatic encode_byte(input byte_item_t it, output bit closed,
			output char_item_t [3:0] group_chars);
		logic [2:0]  count;
		logic [23:0] group;
		int          idx;
		int          k;
		count       = {1'b0, pending_count} + 3'd1;
		closed      = (count == 3'd3) || it.final_byte;
		group_chars = '0;
		if (!closed) begin
			pending_bytes = {pending_bytes[7:0], it.data_byte};
			pending_count = count[1:0];
		end else begin
			// Left align the group; missing low bits stay zero
			case (count)
			3'd1: begin
				group = {it.data_byte, 16'h0000};
			end
			3'd2: begin
				group = {pending_bytes[7:0], it.data_byte, 8'h00};
			end
			default: begin
				group = {pending_bytes, it.data_byte};
			end
			endcase
			for (k = 0; k < 4; k++) begin
				idx = (k > count) ? PAD_SEXTET : int'(group[(3-k)*6 +: 6]);
				group_chars[k].code_char  = sextet_char(idx);
				group_chars[k].final_char = (k == 3) ? it.final_byte : 1'b0;
			end
			pending_bytes = '0;
			pending_count = '0;
		end
	endtask

	// One byte transfer after a random gap; expectations queued on acceptance
	task automatic send_byte(input byte_item_t it, input logic typed,
			input logic [31:0] typed_chars);
		int               gap;
		int               k;
		bit               closed;
		char_item_t [3:0] group_chars;
		gap = byte_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= it;
		do @(posedge clk); while (byte_stall);
		encode_byte(it, closed, group_chars);
		if (closed) begin
			for (k = 0; k < 4; k++) begin
				if (typed) begin
					group_chars[k].code_char = typed_chars[8*(3-k) +: 8];
				end
				expected_chars.insert(expected_chars.size(), group_chars[k]);
			end
		end
	endtask

	// Character side: check each transfer, then draw the next stall
	always @(posedge clk) begin
		char_item_t want;
		if (arst_n && char_valid && !char_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char: expected none, actual %h/%b",
					$time, char_data.code_char, char_data.final_char);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (char_data.code_char !== want.code_char) begin
					$display("%0t: code_char: expected %h, actual %h",
						$time, want.code_char, char_data.code_char);
					errors++;
				end
				if (char_data.final_char !== want.final_char) begin
					$display("%0t: final_char: expected %b, actual %b",
						$time, want.final_char, char_data.final_char);
					errors++;
				end
			end
			if (char_data.final_char)
				char_idle = ($urandom_range(0, 2) != 0);
			char_wait = char_idle ? $urandom_range(0, 3) : 0;
		end else if (char_valid && char_wait > 0) begin
			char_wait--;
		end
		char_stall <= (char_wait > 0);
	end

	// Stimulus: reset, directed rows, random messages, drain
	initial begin
		byte_item_t it;
		int         sent;
		int         len;
		int         n;
		int         r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < ROWS; r++) begin
			it.data_byte  = DIRECTED_ROWS[r].data;
			it.final_byte = DIRECTED_ROWS[r].last;
			send_byte(it, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].chars);
		end

		// Messages of random length; some are whole groups
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			byte_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) == 0)
				len = 3 * $urandom_range(1, 4);
			else
				len = $urandom_range(1, 9);
			for (n = 0; n < len; n++) begin
				case ($urandom_range(0, 7))
				0: begin
					it.data_byte = 8'h00;
				end
				1: begin
					it.data_byte = 8'hFF;
				end
				default: begin
					it.data_byte = 8'($urandom_range(0, 255));
				end
				endcase
				it.final_byte = (n == len - 1);
				send_byte(it, 1'b0, 32'h0);
			end
			sent += len;
		end
		byte_valid <= 1'b0;

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("base64_stream_encoder: match");
		else
			$display("base64_stream_encoder: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#200000;
		$display("base64_stream_encoder: mismatch");
		$finish;
	end

endmodule
